>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL of the range search table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define RMM_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is high
`define RMM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/rmmist_pkg.sv
`default_nettype none

package rmmist_pkg;

  // field widths
  localparam int OP_W       = 1;
  localparam int OFF_W      = 10;
  localparam int LEN_W      = 11;
  localparam int VAL_W      = 64;
  localparam int PT_W       = 32;
  localparam int RES_PT_W   = 33;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W = 272;
  localparam int M_TDATA_W = 264;

  localparam int DEF_TABLE_DEPTH = 1024;

  // request kinds
  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LOAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DOM_BASE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_LENGTH = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;

  // sample strobe travelling alongside the table read data
  typedef struct packed {
    logic             smp_vld;
    logic             smp_first;
    logic [LEN_W-1:0] smp_idx;
  } scan_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/rmmist_ram.sv
`default_nettype none

module rmmist_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rmmist_scan.sv
`default_nettype none

module rmmist_scan (
  input  wire logic                                 clk,
  input  wire rmmist_pkg::scan_ctl_t                ctl,
  input  wire rmmist_pkg::val_t                     smp_value,
  input  wire rmmist_pkg::val_t                     int_low,
  input  wire rmmist_pkg::val_t                     int_high,
  output rmmist_pkg::val_t                          point_value,
  output rmmist_pkg::val_t                          min_value,
  output rmmist_pkg::val_t                          max_value,
  output logic                                      found,
  output logic [rmmist_pkg::LEN_W-1:0]              first_idx,
  output logic [rmmist_pkg::LEN_W-1:0]              last_idx
);

  logic hit;

  // value lies in [low, high)
  assign hit = (smp_value >= int_low) && (smp_value < int_high);

  // first value, running min, max and hit positions, one sample a cycle
  always_ff @(posedge clk) begin
    if (ctl.smp_vld) begin
      if (ctl.smp_first) begin
        point_value <= smp_value;
        min_value   <= smp_value;
        max_value   <= smp_value;
        found       <= hit;
        first_idx   <= ctl.smp_idx;
        last_idx    <= ctl.smp_idx;
      end else begin
        if (smp_value < min_value) begin
          min_value <= smp_value;
        end
        if (smp_value > max_value) begin
          max_value <= smp_value;
        end
        if (hit) begin
          if (!found) begin
            first_idx <= ctl.smp_idx;
          end
          found    <= 1'b1;
          last_idx <= ctl.smp_idx;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/range_min_max_interval_search_table_unit.sv
// Range min/max and interval search over a table of signed 64-bit values.
// Input stream (s_*): one request per beat. tuser = op; op load writes one
// entry, op query scans [begin_pt, end_pt) of the domain.
// Output stream (m_*): one result per request; tuser = status.
// Config channel (cfg_*): index 0 domain base, 1 domain length; always
// ready. The user must write it only while no request is in flight; the
// block does not enforce this. A taken request passes a check state, then,
// for a valid query, a scan state and a drain state, and last a finish state
// that loads the output register; the next request is taken after that.
// The scan reads one table entry a cycle through the single read port of
// the table memory; min, max and the interval hits update as data returns.
// s_tready is high only while idle. A finished result waits in the output
// register while m_tready is low, and a new request is already taken then;
// the block holds the next result until the register empties.
// Reset empties the output register, returns to idle and sets the domain
// base to 0 and the domain length to 1. Table contents are not cleared.
`default_nettype none

`include "assert_macros.svh"

module range_min_max_interval_search_table_unit #(
  parameter int TABLE_DEPTH = rmmist_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // load_offset[9:0], load_value[73:10], begin_pt[105:74],
  // end_pt[137:106], interval_low[201:138], interval_high[265:202], pad
  input  wire logic [rmmist_pkg::S_TDATA_W-1:0]    s_tdata,
  // op[0]
  input  wire logic [rmmist_pkg::OP_W-1:0]         s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // point_value[63:0], range_minimum[127:64], range_maximum[191:128],
  // first_inside[224:192], last_inside[257:225], pad
  output logic      [rmmist_pkg::M_TDATA_W-1:0]    m_tdata,
  // status[1:0]
  output logic      [rmmist_pkg::STATUS_W-1:0]     m_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rmmist_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rmmist_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LEN_W    = rmmist_pkg::LEN_W;
  localparam int PT_W     = rmmist_pkg::PT_W;
  localparam int RES_PT_W = rmmist_pkg::RES_PT_W;
  localparam int VAL_W    = rmmist_pkg::VAL_W;
  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int DW       = $clog2(TABLE_DEPTH + 1);
  localparam int CW       = (DW > LEN_W) ? DW : LEN_W;
  localparam int XW       = (AW > LEN_W) ? AW : LEN_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;

  // configuration
  logic signed [PT_W-1:0] dom_base;
  logic [LEN_W-1:0]       domain_length;
  logic [LEN_W-1:0]       eff_len;

  // captured request
  logic [rmmist_pkg::OP_W-1:0]  q_op;
  logic [rmmist_pkg::OFF_W-1:0] q_off;
  rmmist_pkg::val_t             q_val;
  logic signed [PT_W-1:0]       q_b;
  logic signed [PT_W-1:0]       q_e;
  rmmist_pkg::val_t             q_lo;
  rmmist_pkg::val_t             q_hi;
  logic [rmmist_pkg::STATUS_W-1:0] q_status;

  // scan sequencer
  logic [LEN_W-1:0]      scan_k;
  logic [LEN_W-1:0]      scan_end;
  logic [LEN_W-1:0]      scan_k_inc;
  logic                  first_pend;
  rmmist_pkg::scan_ctl_t scan_ctl;

  // bound checks
  logic signed [RES_PT_W-1:0] start_x;
  logic signed [RES_PT_W-1:0] b_x;
  logic signed [RES_PT_W-1:0] e_x;
  logic signed [RES_PT_W-1:0] b_off;
  logic signed [RES_PT_W-1:0] e_off;
  logic signed [RES_PT_W-1:0] len_x;
  logic                       query_ok;
  logic                       load_ok;

  // table memory
  logic             wr_en;
  logic [XW-1:0]    wr_addr_x;
  logic [XW-1:0]    rd_addr_x;
  logic             rd_en;
  logic [VAL_W-1:0] rd_data;

  // scan results
  rmmist_pkg::val_t point_value;
  rmmist_pkg::val_t min_value;
  rmmist_pkg::val_t max_value;
  logic             found;
  logic [LEN_W-1:0] first_idx;
  logic [LEN_W-1:0] last_idx;

  // result assembly
  logic signed [RES_PT_W-1:0] first_pt;
  logic signed [RES_PT_W-1:0] last_pt;
  logic                       out_load;
  logic                       res_full;
  logic [rmmist_pkg::M_TDATA_W-1:0] res_data;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dom_base      <= '0;
      domain_length <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rmmist_pkg::CFG_DOM_BASE:      dom_base      <= cfg_data[PT_W-1:0];
        rmmist_pkg::CFG_DOMAIN_LENGTH: domain_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length saturated to the table depth
  assign eff_len = (CW'(domain_length) > CW'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                           : domain_length;

  // bounds, all in 33-bit signed
  assign start_x  = {dom_base[PT_W-1], dom_base};
  assign b_x      = {q_b[PT_W-1], q_b};
  assign e_x      = {q_e[PT_W-1], q_e};
  assign b_off    = b_x - start_x;
  assign e_off    = e_x - start_x;
  assign len_x    = $signed({{(RES_PT_W-LEN_W){1'b0}}, eff_len});
  assign query_ok = (q_b >= dom_base) && (q_b < q_e) && (e_off <= len_x) &&
                    (q_lo < q_hi);
  assign load_ok  = (LEN_W'(q_off) < eff_len);

  // table access
  assign wr_en      = (state == S_CHECK) && (q_op == rmmist_pkg::OP_LOAD) && load_ok;
  assign wr_addr_x  = XW'(q_off);
  assign rd_en      = (state == S_SCAN);
  assign rd_addr_x  = XW'(scan_k);
  assign scan_k_inc = scan_k + LEN_W'(1);

  rmmist_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr_x[AW-1:0]),
    .wr_data (q_val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_x[AW-1:0]),
    .rd_data (rd_data)
  );

  rmmist_scan u_scan (
    .clk         (clk),
    .ctl         (scan_ctl),
    .smp_value   ($signed(rd_data)),
    .int_low     (q_lo),
    .int_high    (q_hi),
    .point_value (point_value),
    .min_value   (min_value),
    .max_value   (max_value),
    .found       (found),
    .first_idx   (first_idx),
    .last_idx    (last_idx)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      q_op  <= s_tuser;
      q_off <= s_tdata[9:0];
      q_val <= s_tdata[73:10];
      q_b   <= s_tdata[105:74];
      q_e   <= s_tdata[137:106];
      q_lo  <= s_tdata[201:138];
      q_hi  <= s_tdata[265:202];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      scan_ctl.smp_vld <= 1'b0;
    end else begin
      scan_ctl.smp_vld <= (state == S_SCAN);
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (q_op == rmmist_pkg::OP_LOAD) begin
            q_status <= load_ok ? rmmist_pkg::ST_OK : rmmist_pkg::ST_LOAD_RANGE;
            state    <= S_FINISH;
          end else if (!query_ok) begin
            q_status <= rmmist_pkg::ST_BAD_QUERY;
            state    <= S_FINISH;
          end else begin
            q_status   <= rmmist_pkg::ST_OK;
            scan_k     <= b_off[LEN_W-1:0];
            scan_end   <= e_off[LEN_W-1:0];
            first_pend <= 1'b1;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_ctl.smp_first <= first_pend;
          scan_ctl.smp_idx   <= scan_k;
          first_pend         <= 1'b0;
          scan_k             <= scan_k_inc;
          if (scan_k_inc == scan_end) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last sample is being folded in this cycle
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // domain points of the hits, or the empty-search values
  assign first_pt = found ? (start_x + $signed({{(RES_PT_W-LEN_W){1'b0}}, first_idx}))
                          : e_x;
  assign last_pt  = found ? (start_x + $signed({{(RES_PT_W-LEN_W){1'b0}}, last_idx}))
                          : (b_x - RES_PT_W'(1));

  assign res_full = (q_op == rmmist_pkg::OP_QUERY) && (q_status == rmmist_pkg::ST_OK);
  assign res_data = res_full ? {{(rmmist_pkg::M_TDATA_W - 3*VAL_W - 2*RES_PT_W){1'b0}},
                                last_pt, first_pt, max_value, min_value, point_value}
                             : '0;

  assign out_load = (state == S_FINISH) && (!m_tvalid || m_tready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_data;
      m_tuser <= q_status;
    end
  end

  // checks
  `RMM_ASSERT_IMPL(a_scan_in_range, clk, rst, state == S_SCAN, scan_k < scan_end)
  `RMM_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `RMM_ASSERT_NEXT(a_read_gives_sample, clk, rst, state == S_SCAN, scan_ctl.smp_vld)
  `RMM_ASSERT_IMPL(a_zero_on_fail, clk, rst, m_tvalid && (m_tuser != rmmist_pkg::ST_OK), m_tdata == '0)

endmodule

`default_nettype wire

>>> tb/range_min_max_interval_search_table_unit_tb.sv
`timescale 1ns / 100ps

module range_min_max_interval_search_table_unit_tb;
  import rmmist_pkg::*;

  localparam int DEPTH         = DEF_TABLE_DEPTH;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 8;

  localparam logic signed [PT_W-1:0]  PT_MIN  = 32'sh8000_0000;
  localparam logic signed [PT_W-1:0]  PT_MAX  = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7fff_ffff_ffff_ffff;

  typedef struct {
    logic [OP_W-1:0]        op;
    logic [OFF_W-1:0]       load_offset;
    val_t                   load_value;
    logic signed [PT_W-1:0] begin_pt;
    logic signed [PT_W-1:0] end_pt;
    val_t                   interval_low;
    val_t                   interval_high;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0]        status;
    val_t                       point_value;
    val_t                       range_minimum;
    val_t                       range_maximum;
    logic signed [RES_PT_W-1:0] first_inside;
    logic signed [RES_PT_W-1:0] last_inside;
  } result_t;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_W-1:0]    s_tdata   = '0;
  logic [OP_W-1:0]         s_tuser   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]    m_tdata;
  logic [STATUS_W-1:0]     m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  // shadow of the block: table contents, which entries hold data, registers
  val_t                    shadow_values [DEPTH];
  bit                      entry_written [DEPTH];
  logic signed [PT_W-1:0]  dom_start = '0;
  logic [LEN_W-1:0]        dom_len   = 11'd1;
  result_t                 expected_results [$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int tx_burst_left = 0;
  int rx_left       = 0;
  rx_mode_t rx_mode = RX_STEADY;
  int n_loads_ok = 0, n_loads_refused = 0, n_scans = 0, n_scan_hits = 0;
  int n_queries_refused = 0, n_reg_writes = 0;

  range_min_max_interval_search_table_unit #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic int effective_length();
    return (dom_len > DEPTH) ? DEPTH : int'(dom_len);
  endfunction

  function automatic bit bounds_valid(logic signed [PT_W-1:0] b, logic signed [PT_W-1:0] e,
                                      val_t lo, val_t hi);
    logic signed [63:0] b64, e64, s64;
    b64 = b;
    e64 = e;
    s64 = dom_start;
    return (s64 <= b64) && (b64 < e64) && (e64 <= s64 + effective_length()) && (lo < hi);
  endfunction

  // expected result of one request; loads update the shadow table
  function automatic result_t predict_result(request_t r);
    result_t            res;
    logic signed [63:0] b64, e64, s64, first, last;
    val_t               v, mn, mx;
    int                 ob, oe;
    bit                 found;
    res = '{default: '0};
    if (r.op == OP_LOAD) begin
      if (int'(r.load_offset) >= effective_length()) begin
        res.status = ST_LOAD_RANGE;
        n_loads_refused++;
      end else begin
        shadow_values[r.load_offset] = r.load_value;
        entry_written[r.load_offset] = 1'b1;
        n_loads_ok++;
      end
      return res;
    end
    if (!bounds_valid(r.begin_pt, r.end_pt, r.interval_low, r.interval_high)) begin
      res.status = ST_BAD_QUERY;
      n_queries_refused++;
      return res;
    end
    b64   = r.begin_pt;
    e64   = r.end_pt;
    s64   = dom_start;
    ob    = int'(b64 - s64);
    oe    = int'(e64 - s64);
    mn    = shadow_values[ob];
    mx    = mn;
    first = e64;
    last  = b64 - 1;
    found = 1'b0;
    for (int k = ob; k < oe; k++) begin
      v = shadow_values[k];
      if (v < mn) mn = v;
      if (v > mx) mx = v;
      if (r.interval_low <= v && v < r.interval_high) begin
        if (!found) first = s64 + k;
        found = 1'b1;
        last  = s64 + k;
      end
    end
    res.status        = ST_OK;
    res.point_value   = shadow_values[ob];
    res.range_minimum = mn;
    res.range_maximum = mx;
    res.first_inside  = first[RES_PT_W-1:0];
    res.last_inside   = last[RES_PT_W-1:0];
    n_scans++;
    if (found) n_scan_hits++;
    return res;
  endfunction

  // mix of extremes, small values for ties and hits, and full-width noise
  function automatic val_t rand_value();
    case ($urandom_range(0, 5))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return val_t'($urandom_range(0, 40)) - 64'sd20;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic request_t load_req(int off, val_t val);
    request_t r;
    r.op            = OP_LOAD;
    r.load_offset   = off[OFF_W-1:0];
    r.load_value    = val;
    r.begin_pt      = $urandom;
    r.end_pt        = $urandom;
    r.interval_low  = {$urandom, $urandom};
    r.interval_high = {$urandom, $urandom};
    return r;
  endfunction

  function automatic request_t query_req(logic signed [PT_W-1:0] b, logic signed [PT_W-1:0] e,
                                         val_t lo, val_t hi);
    request_t r;
    r.op            = OP_QUERY;
    r.load_offset   = $urandom;
    r.load_value    = {$urandom, $urandom};
    r.begin_pt      = b;
    r.end_pt        = e;
    r.interval_low  = lo;
    r.interval_high = hi;
    return r;
  endfunction

  // send one request; the sender runs in bursts with random gaps between them
  task automatic send_request(request_t r);
    int gap;
    if (tx_burst_left == 0) begin
      gap           = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      tx_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tx_burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= S_TDATA_W'({r.interval_high, r.interval_low, r.end_pt, r.begin_pt,
                            r.load_value, r.load_offset});
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_result(r));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_until_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DOM_BASE) dom_start = data;
    else                     dom_len   = data[LEN_W-1:0];
    n_reg_writes++;
  endtask

  // length goes out with junk in the unused upper bits
  task automatic set_domain(logic signed [PT_W-1:0] start, logic [LEN_W-1:0] len);
    wait_until_idle();
    write_register(CFG_DOM_BASE, start);
    write_register(CFG_DOMAIN_LENGTH, {21'($urandom), len});
  endtask

  // result checker: oldest expectation against each accepted result
  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding, status %0d", m_tuser);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, m_tuser);
        check_field("point_value", want.point_value, $signed(m_tdata[63:0]));
        check_field("range_minimum", want.range_minimum, $signed(m_tdata[127:64]));
        check_field("range_maximum", want.range_maximum, $signed(m_tdata[191:128]));
        check_field("first_inside", want.first_inside, $signed(m_tdata[224:192]));
        check_field("last_inside", want.last_inside, $signed(m_tdata[257:225]));
      end
    end
  end

  // receiver: switches at random between stall patterns
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_left  <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_STEADY: m_tready <= 1'b1;
        RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ((rx_left % 8) < 3);
      endcase
    end
  end

  // defaults after reset: domain [0,1), refusals of every kind, hit and miss
  task automatic test_reset_state();
    send_request(load_req(0, VAL_MIN));
    send_request(load_req(DEPTH - 1, rand_value()));
    send_request(query_req(0, 1, VAL_MIN, VAL_MAX));
    send_request(query_req(0, 1, 0, 1));
    send_request(query_req(0, 1, 5, 5));
    send_request(query_req(0, 2, VAL_MIN, VAL_MAX));
    send_request(query_req(-1, 0, VAL_MIN, VAL_MAX));
    send_request(query_req(0, 0, VAL_MIN, VAL_MAX));
  endtask

  // domain at the bottom of the point range, full table, value extremes
  task automatic test_wide_domain();
    set_domain(PT_MIN, DEPTH);
    send_request(load_req(0, VAL_MAX));
    send_request(load_req(1, VAL_MIN));
    send_request(load_req(2, 0));
    send_request(load_req(DEPTH - 2, 5));
    send_request(load_req(DEPTH - 1, -1));
    send_request(query_req(PT_MIN, PT_MIN + 3, -1, 1));
    // miss at the very bottom: begin minus one needs the 33rd bit
    send_request(query_req(PT_MIN, PT_MIN + 2, 0, 1));
    send_request(query_req(PT_MIN + DEPTH - 2, PT_MIN + DEPTH, VAL_MIN, VAL_MAX));
    send_request(query_req(PT_MIN + DEPTH - 1, PT_MIN + DEPTH + 1, VAL_MIN, VAL_MAX));
  endtask

  // domain ending at the top of the point range, length saturated to depth
  task automatic test_top_of_domain();
    set_domain(PT_MAX - (DEPTH - 1), 11'h7ff);
    send_request(query_req(PT_MAX - 1, PT_MAX, 6, 7));
    send_request(query_req(PT_MAX - 1, PT_MAX, 5, 6));
    send_request(load_req(DEPTH - 1, rand_value()));
    send_request(query_req(PT_MAX, PT_MAX, VAL_MIN, VAL_MAX));
  endtask

  // zero length refuses everything; just over depth behaves as depth
  task automatic test_length_limits();
    set_domain(0, 0);
    send_request(load_req(0, rand_value()));
    send_request(query_req(0, 1, VAL_MIN, VAL_MAX));
    set_domain(-5, DEPTH + 1);
    send_request(load_req(DEPTH - 1, rand_value()));
    send_request(query_req(DEPTH - 6, DEPTH - 5, VAL_MIN, VAL_MAX));
  endtask

  // one phase of mixed traffic under the current domain
  task automatic run_traffic_phase(int n_items);
    int                 eff, sent, pick, ob, run, n_ent, off, grow, k;
    logic signed [63:0] s64, b64, e64;
    val_t               lo, hi, v;
    request_t           r;
    eff  = effective_length();
    s64  = dom_start;
    sent = 0;
    // make sure the low entries hold data so short scans have somewhere to go
    for (off = 0; off < eff && off < 24 && sent < n_items; off++) begin
      if (!entry_written[off]) begin
        send_request(load_req(off, rand_value()));
        sent++;
      end
    end
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      ob   = -1;
      if (pick >= 25 && pick < 80 && eff > 0) begin
        for (int t = 0; t < 8 && ob < 0; t++) begin
          k = $urandom_range(0, eff - 1);
          if (entry_written[k]) ob = k;
        end
      end

      if (pick < 25) begin
        // loads: grow the written prefix, scatter, or aim past the length
        grow = 0;
        while (grow < eff && entry_written[grow]) grow++;
        if (pick < 10 && grow < eff)  off = grow;
        else if (pick < 22 && eff > 0) off = $urandom_range(0, eff - 1);
        else                           off = $urandom_range(0, DEPTH - 1);
        r = load_req(off, rand_value());
      end else if (ob >= 0 && s64 + ob + 1 <= PT_MAX) begin
        // well-formed scan over entries that hold data
        run = 0;
        while (ob + run < eff && entry_written[ob + run]) run++;
        while (run > 1 && s64 + ob + run > PT_MAX) run--;
        n_ent = ($urandom_range(0, 6) == 0) ? $urandom_range(1, run)
                                            : $urandom_range(1, (run < 12) ? run : 12);
        b64 = s64 + ob;
        e64 = b64 + n_ent;
        case ($urandom_range(0, 3))
          0: begin
            lo = VAL_MIN;
            hi = VAL_MAX;
          end
          1: begin
            v  = shadow_values[ob + $urandom_range(0, n_ent - 1)];
            lo = (v > VAL_MIN + 3) ? v - $urandom_range(0, 3) : v;
            hi = (lo < VAL_MAX - 40) ? lo + 1 + $urandom_range(0, 30) : VAL_MAX;
          end
          2: begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (lo > hi) begin
              v  = lo;
              lo = hi;
              hi = v;
            end
            if (lo == hi) hi = lo + 1;
          end
          default: begin
            lo = rand_value();
            hi = lo + 1;
          end
        endcase
        r = query_req(b64[PT_W-1:0], e64[PT_W-1:0], lo, hi);
      end else begin
        // broken queries: empty or reversed range, out of domain, bad interval
        b64 = s64 + $urandom_range(0, eff);
        e64 = b64 + 1 + $urandom_range(0, 3);
        lo  = rand_value();
        hi  = lo + 1 + $urandom_range(0, 1000);
        case ($urandom_range(0, 6))
          0: e64 = b64;
          1: e64 = b64 - 1 - $urandom_range(0, 3);
          2: e64 = s64 + eff + 1 + $urandom_range(0, 3);
          3: b64 = s64 - 1 - $urandom_range(0, 3);
          4: hi = lo;
          5: begin
            v  = lo;
            lo = hi;
            hi = v;
          end
          default: begin
            b64 = $signed($urandom);
            e64 = $signed($urandom);
            lo  = {$urandom, $urandom};
            hi  = {$urandom, $urandom};
          end
        endcase
        r = query_req(b64[PT_W-1:0], e64[PT_W-1:0], lo, hi);
        // one that came out valid by accident must not scan unloaded entries
        if (bounds_valid(r.begin_pt, r.end_pt, r.interval_low, r.interval_high)) begin
          b64 = r.begin_pt;
          e64 = r.end_pt;
          for (k = int'(b64 - s64); k < int'(e64 - s64); k++) begin
            if (!entry_written[k]) r.interval_high = r.interval_low;
          end
        end
      end
      send_request(r);
      sent++;
    end
  endtask

  // random traffic over a series of domain settings
  task automatic test_random_traffic();
    logic signed [PT_W-1:0] start;
    logic [LEN_W-1:0]       len;
    int                     n;
    for (int p = 0; p < 10; p++) begin
      n     = 64;
      len   = $urandom_range(1, 64);
      start = $urandom_range(0, 4000) - 2000;
      case (p)
        0: start = 0;
        1: start = PT_MIN;
        2: start = $urandom;
        3: len = DEPTH;
        4: start = PT_MAX - len;
        5: begin
          start = PT_MAX;
          len   = 16;
          n     = 20;
        end
        6: begin
          start = $urandom;
          len   = 11'h7ff;
        end
        7: begin
          len = 0;
          n   = 20;
        end
        8: len = $urandom_range(65, DEPTH - 1);
        default: ;
      endcase
      set_domain(start, len);
      run_traffic_phase(n);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_wide_domain();
    test_top_of_domain();
    test_length_limits();
    test_random_traffic();
    wait_until_idle();
    $display("run covered %0d loads stored, %0d refused past the length, %0d register writes",
             n_loads_ok, n_loads_refused, n_reg_writes);
    $display("range scans %0d (%0d with interval hits), queries refused %0d, cycles %0d",
             n_scans, n_scan_hits, n_queries_refused, cycle_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/rmmist_pkg.sv
rtl/core/rmmist_ram.sv
rtl/core/rmmist_scan.sv
rtl/core/range_min_max_interval_search_table_unit.sv
tb/range_min_max_interval_search_table_unit_tb.sv
